// ----- rtl/chacha20_stream_cipher_top_assert.svh -----
// assertion macros shared by the cipher rtl
`ifndef CHACHA20_STREAM_CIPHER_TOP_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_TOP_ASSERT_SVH

// property that must hold on every clock edge out of reset
`define CC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked in the cycle after the condition
`define CC_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ----- rtl/cc20_pkg.sv -----
`default_nettype none
package cc20_pkg;
	localparam int unsigned DoubleRounds = 10;
	localparam int unsigned BytesPerItem = 8;
	localparam int unsigned QueueDepth = 2;

	localparam logic [2:0] RegKey0 = 3'd0;
	localparam logic [2:0] RegKey1 = 3'd1;
	localparam logic [2:0] RegKey2 = 3'd2;
	localparam logic [2:0] RegKey3 = 3'd3;
	localparam logic [2:0] RegNonce = 3'd4;
	localparam logic [2:0] RegStart = 3'd5;

	localparam logic [31:0] Sigma0 = 32'h61707865;
	localparam logic [31:0] Sigma1 = 32'h3320646e;
	localparam logic [31:0] Sigma2 = 32'h79622d32;
	localparam logic [31:0] Sigma3 = 32'h6b206574;

	typedef struct packed {
		logic [63:0] data_in;
		logic [3:0]  byte_count;
		logic        first;
	} in_item_t;

	typedef struct packed {
		logic [63:0] data_out;
		logic [3:0]  valid_bytes;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  count;
		logic        first;
	} work_t;

	typedef logic [15:0][31:0] state_t;

	typedef struct packed {
		logic [255:0] key;
		logic [63:0]  nonce;
		logic [63:0]  start;
	} cfg_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [127:0] qr(input logic [31:0] a_i, input logic [31:0] b_i,
			input logic [31:0] c_i, input logic [31:0] d_i);
		logic [31:0] a, b, c, d;
		a = a_i; b = b_i; c = c_i; d = d_i;
		a = a + b; d = rotl(d ^ a, 16);
		c = c + d; b = rotl(b ^ c, 12);
		a = a + b; d = rotl(d ^ a, 8);
		c = c + d; b = rotl(b ^ c, 7);
		qr = {a, b, c, d};
	endfunction
endpackage
`default_nettype wire

// ----- rtl/cc20_front.sv -----
`default_nettype none
module cc20_front #(
	parameter int unsigned BYTES_PER_ITEM = cc20_pkg::BytesPerItem,
	parameter int unsigned QUEUE_DEPTH = cc20_pkg::QueueDepth
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	input  cc20_pkg::in_item_t in_item,
	output logic             q_valid,
	input  wire              q_pop,
	output cc20_pkg::work_t  q_head
);
	import cc20_pkg::*;
	localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	work_t mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic push;
	work_t cls;

	// saturate byte count into 1..BYTES_PER_ITEM
	always_comb begin
		cls.data = in_item.data_in;
		cls.first = in_item.first;
		if (in_item.byte_count == 4'd0)
			cls.count = 4'd1;
		else if (in_item.byte_count > 4'(BYTES_PER_ITEM))
			cls.count = 4'(BYTES_PER_ITEM);
		else
			cls.count = in_item.byte_count;
	end

	assign in_stall = (cnt_q == (AW+1)'(QUEUE_DEPTH));
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != '0);
	assign q_head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (q_pop)
				rd_q <= (rd_q == AW'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop);
		end
	end

	`include "chacha20_stream_cipher_top_assert.svh"
	`CC_ASSERT(a_no_pop_empty, !(q_pop && !q_valid), "pop from empty queue")
	`CC_ASSERT(a_cnt_bound, cnt_q <= (AW+1)'(QUEUE_DEPTH), "queue count overflow")
	`CC_ASSERT_NEXT(a_push_fills, push && !q_pop, cnt_q == $past(cnt_q) + 1'b1,
		"queue count did not rise on push")
endmodule
`default_nettype wire

// ----- rtl/cc20_core.sv -----
`default_nettype none
// one column or diagonal round per cycle
module cc20_core #(
	parameter int unsigned DOUBLE_ROUNDS = cc20_pkg::DoubleRounds
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  cc20_pkg::state_t init,
	output logic             done,
	output logic [511:0]     block
);
	import cc20_pkg::*;
	localparam int unsigned RW = $clog2(2*DOUBLE_ROUNDS + 1);

	state_t x_q, init_q, nx;
	logic [RW-1:0] rnd_q;
	logic busy_q;

	always_comb begin
		nx = x_q;
		if (!rnd_q[0]) begin
			for (int i = 0; i < 4; i++)
				{nx[i], nx[4+i], nx[8+i], nx[12+i]} = qr(x_q[i], x_q[4+i], x_q[8+i], x_q[12+i]);
		end else begin
			for (int i = 0; i < 4; i++)
				{nx[i], nx[4+(i+1)%4], nx[8+(i+2)%4], nx[12+(i+3)%4]} =
					qr(x_q[i], x_q[4+(i+1)%4], x_q[8+(i+2)%4], x_q[12+(i+3)%4]);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= init;
			init_q <= init;
		end else if (busy_q) begin
			x_q <= nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			rnd_q <= '0;
		end else if (busy_q) begin
			rnd_q <= rnd_q + 1'b1;
			if (rnd_q == RW'(2*DOUBLE_ROUNDS-1))
				busy_q <= 1'b0;
		end
	end

	assign done = !busy_q;
	// feed-forward
	always_comb begin
		for (int i = 0; i < 16; i++)
			block[32*i +: 32] = x_q[i] + init_q[i];
	end
endmodule
`default_nettype wire

// ----- rtl/cc20_back.sv -----
`default_nettype none
module cc20_back #(
	parameter int unsigned DOUBLE_ROUNDS = cc20_pkg::DoubleRounds
) (
	input  wire              clk,
	input  wire              arst_n,
	input  cc20_pkg::cfg_t   cfg,
	input  wire              q_valid,
	output logic             q_pop,
	input  cc20_pkg::work_t  q_head,
	output logic             out_valid,
	input  wire              out_stall,
	output cc20_pkg::out_item_t out_item
);
	import cc20_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_GEN  = 4'b0010,
		ST_WAIT = 4'b0100,
		ST_EMIT = 4'b1000
	} st_t;

	st_t st_q;
	logic [511:0] ks_q;
	logic [5:0] pos_q;
	logic bv_q;
	logic [63:0] ctr_q;
	logic [3:0] idx_q;
	logic [63:0] acc_q;
	logic [63:0] acc_nx;
	logic core_start, core_done;
	logic [511:0] core_blk;
	state_t init;
	logic [63:0] ctr_use;
	logic out_free;
	work_t cur_q;
	logic [63:0] q_head_d_q;
	out_item_t out_q;
	logic last_byte;
	logic emit_go;
	logic finish;

	// per-item counter view after a first flag reload
	assign ctr_use = ctr_q;
	always_comb begin
		init[0] = Sigma0; init[1] = Sigma1; init[2] = Sigma2; init[3] = Sigma3;
		for (int i = 0; i < 8; i++)
			init[4+i] = cfg.key[32*i +: 32];
		init[12] = ctr_use[31:0];
		init[13] = ctr_use[63:32];
		init[14] = cfg.nonce[31:0];
		init[15] = cfg.nonce[63:32];
	end

	cc20_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
		.clk(clk), .arst_n(arst_n), .start(core_start), .init(init),
		.done(core_done), .block(core_blk)
	);

	assign q_head_d_q = cur_q.data;
	assign out_free = !out_valid || !out_stall;
	assign core_start = (st_q == ST_GEN);
	assign q_pop = (st_q == ST_IDLE) && q_valid;
	// the last byte of an item waits until the output register is free
	assign last_byte = (idx_q + 4'd1 == cur_q.count);
	assign emit_go = bv_q && (!last_byte || out_free);
	assign finish = (st_q == ST_EMIT) && emit_go && last_byte;

	always_comb begin
		acc_nx = acc_q;
		acc_nx[8*idx_q[2:0] +: 8] = q_head_d_q[8*idx_q[2:0] +: 8] ^ ks_q[8*pos_q +: 8];
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			acc_q <= '0;
		else if (st_q == ST_EMIT && emit_go)
			acc_q <= acc_nx;
		if (st_q == ST_WAIT && core_done)
			ks_q <= core_blk;
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_head;
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q.data_out <= acc_nx;
			out_q.valid_bytes <= cur_q.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			pos_q <= '0;
			bv_q <= 1'b0;
			ctr_q <= '0;
			idx_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (finish)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (q_pop) begin
						idx_q <= '0;
						if (q_head.first) begin
							ctr_q <= cfg.start;
							bv_q <= 1'b0;
							pos_q <= '0;
						end
						st_q <= ST_EMIT;
					end
				end
				ST_GEN: st_q <= ST_WAIT;
				ST_WAIT: begin
					if (core_done) begin
						bv_q <= 1'b1;
						pos_q <= '0;
						ctr_q <= ctr_q + 64'd1;
						st_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!bv_q) begin
						st_q <= ST_GEN;
					end else if (emit_go) begin
						pos_q <= pos_q + 6'd1;
						if (pos_q == 6'd63)
							bv_q <= 1'b0;
						idx_q <= idx_q + 4'd1;
						if (last_byte)
							st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_item = out_q;

	`include "chacha20_stream_cipher_top_assert.svh"
	`CC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item),
		"result changed while stalled")
	`CC_ASSERT_NEXT(a_gen_to_wait, st_q == ST_GEN, st_q == ST_WAIT, "generation did not start")
	`CC_ASSERT(a_onehot, $onehot(st_q), "state not one-hot")
endmodule
`default_nettype wire

// ----- rtl/chacha20_stream_cipher_top.sv -----
// ChaCha20 (64-bit counter, 64-bit nonce) byte-stream cipher. Items of up to eight bytes
// enter through a two-entry queue and are xored with keystream one byte per cycle while
// keystream is at hand and, for the last byte, the output register is free; a fresh 64-byte
// block is computed whenever one is needed, one round per cycle in a single round unit.
// A first flag reloads the block counter from the start register and drops leftover keystream.
// Write configuration only while idle.
`default_nettype none
module chacha20_stream_cipher_top #(
	parameter int unsigned DOUBLE_ROUNDS = cc20_pkg::DoubleRounds,
	parameter int unsigned BYTES_PER_ITEM = cc20_pkg::BytesPerItem
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  cc20_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  wire                 out_stall,
	output cc20_pkg::out_item_t out_item,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire [2:0]           cfg_index,
	input  wire [63:0]          cfg_data
);
	import cc20_pkg::*;

	cfg_t cfg_q;
	logic q_valid, q_pop;
	work_t q_head;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				RegKey0: cfg_q.key[63:0] <= cfg_data;
				RegKey1: cfg_q.key[127:64] <= cfg_data;
				RegKey2: cfg_q.key[191:128] <= cfg_data;
				RegKey3: cfg_q.key[255:192] <= cfg_data;
				RegNonce: cfg_q.nonce <= cfg_data;
				RegStart: cfg_q.start <= cfg_data;
				default: ;
			endcase
		end
	end

	cc20_front #(.BYTES_PER_ITEM(BYTES_PER_ITEM)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
	);

	cc20_back #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_valid(q_valid), .q_pop(q_pop),
		.q_head(q_head), .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);
endmodule
`default_nettype wire
